FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a rising clock edge, off while reset is low.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for a check that only looks at a valid result.
`define ASSERT_ON_VALID(label, clk, rst_n, vld, prop, msg) \
    `ASSERT_SYNC(label, clk, rst_n, (vld) |-> (prop), msg)

`endif

FILE: hw/rtl/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg
// Shared codes, constants, types and character helpers of the reassembler.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int PAYLOAD_MAX_DEF = 4096;
    localparam int CHUNK_SLOTS_DEF = 64;

    localparam logic [23:0] TIMEOUT_RESET = 24'd30000;
    localparam logic [23:0] TICK_SAT      = 24'hFFFFFF;

    localparam logic [2:0] CMD_BYTE  = 3'd0;
    localparam logic [2:0] CMD_TICK  = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_START = 3'd3;
    localparam logic [2:0] CMD_LOST  = 3'd4;
    localparam logic [2:0] CMD_CLEAR = 3'd5;

    localparam logic [2:0] PH_OFF      = 3'd0;
    localparam logic [2:0] PH_WAIT     = 3'd1;
    localparam logic [2:0] PH_RECV     = 3'd2;
    localparam logic [2:0] PH_COMPLETE = 3'd3;
    localparam logic [2:0] PH_ERROR    = 3'd4;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_INVALID = 3'd1;
    localparam logic [2:0] ERR_LARGE   = 3'd2;
    localparam logic [2:0] ERR_TIMEOUT = 3'd3;
    localparam logic [2:0] ERR_LOST    = 3'd4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [16:0] NUM_SAT = 17'h1FFFF;
    localparam logic [15:0] IDX_SAT = 16'hFFFF;
    localparam logic [3:0]  POS_SAT = 4'd8;
    localparam logic [3:0]  END_LEN = 4'd5;

    typedef struct packed {
        logic        begin_ok;
        logic        end_ok;
        logic [3:0]  trim;
        logic        size_done;
        logic        size_neg;
        logic        num_neg;
        logic [16:0] header_size;
        logic [16:0] number;
        logic        colon_seen;
        logic        idx_any;
        logic        idx_bad;
        logic [15:0] index;
    } t_line_info;

    function automatic logic [7:0] begin_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0:    c = 8'h51;
            3'd1:    c = 8'h52;
            3'd2:    c = 8'h42;
            3'd3:    c = 8'h45;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h49;
            3'd6:    c = 8'h4E;
            default: c = CH_COLON;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] end_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0:    c = 8'h51;
            3'd1:    c = 8'h52;
            3'd2:    c = 8'h45;
            3'd3:    c = 8'h4E;
            3'd4:    c = 8'h44;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

FILE: hw/rtl/clt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module clt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/clt_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_line_parser
// Per-byte line scanner: keyword match, header numbers, chunk index, length.
// ----------------------------------------------------------------------------
module clt_line_parser #(
    parameter int PAYLOAD_MAX = clt_pkg::PAYLOAD_MAX_DEF,
    localparam int DW = $clog2(PAYLOAD_MAX + 2)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_feed,
    input  logic               i_clear,
    input  logic [7:0]         i_byte,
    output clt_pkg::t_line_info o_info,
    output logic [DW-1:0]      o_data_pos,
    output logic [DW-1:0]      o_kept_length
);

    localparam logic [DW-1:0] DSAT = DW'(PAYLOAD_MAX + 1);

    logic [3:0]    r_pos, n_pos;
    logic [3:0]    r_trim, n_trim;
    logic          r_begin_ok, n_begin_ok;
    logic          r_end_ok, n_end_ok;
    logic          r_size_done, n_size_done;
    logic          r_size_neg, n_size_neg;
    logic          r_neg, n_neg;
    logic [1:0]    r_ns, n_ns;
    logic [16:0]   r_acc, n_acc;
    logic [16:0]   r_hsize, n_hsize;
    logic          r_colon, n_colon;
    logic          r_idx_any, n_idx_any;
    logic          r_idx_bad, n_idx_bad;
    logic [15:0]   r_idx, n_idx;
    logic [DW-1:0] r_data_pos, n_data_pos;
    logic [DW-1:0] r_kept, n_kept;

    logic [20:0] acc_mul;
    logic [19:0] idx_mul;

    assign acc_mul = 21'(r_acc) * 21'd10 + 21'(i_byte[3:0]);
    assign idx_mul = 20'(r_idx) * 20'd10 + 20'(i_byte[3:0]);

    always_comb begin
        n_pos       = r_pos;
        n_trim      = r_trim;
        n_begin_ok  = r_begin_ok;
        n_end_ok    = r_end_ok;
        n_size_done = r_size_done;
        n_size_neg  = r_size_neg;
        n_neg       = r_neg;
        n_ns        = r_ns;
        n_acc       = r_acc;
        n_hsize     = r_hsize;
        n_colon     = r_colon;
        n_idx_any   = r_idx_any;
        n_idx_bad   = r_idx_bad;
        n_idx       = r_idx;
        n_data_pos  = r_data_pos;
        n_kept      = r_kept;
        if (i_clear) begin
            n_pos       = '0;
            n_trim      = '0;
            n_begin_ok  = 1'b1;
            n_end_ok    = 1'b1;
            n_size_done = 1'b0;
            n_size_neg  = 1'b0;
            n_neg       = 1'b0;
            n_ns        = '0;
            n_acc       = '0;
            n_hsize     = '0;
            n_colon     = 1'b0;
            n_idx_any   = 1'b0;
            n_idx_bad   = 1'b0;
            n_idx       = '0;
            n_data_pos  = '0;
            n_kept      = '0;
        end else if (i_feed) begin
            if (r_pos < 4'd8 && i_byte != clt_pkg::begin_char(r_pos[2:0])) begin
                n_begin_ok = 1'b0;
            end
            if (r_pos < clt_pkg::END_LEN && i_byte != clt_pkg::end_char(r_pos[2:0])) begin
                n_end_ok = 1'b0;
            end
            if (i_byte != clt_pkg::CH_CR) begin
                n_trim = r_pos + 4'd1;
            end
            // header numbers after the keyword
            if (r_pos >= 4'd8 && r_begin_ok) begin
                if (!r_size_done && i_byte == clt_pkg::CH_COLON) begin
                    n_hsize     = r_acc;
                    n_size_neg  = r_neg;
                    n_size_done = 1'b1;
                    n_ns        = 2'd0;
                    n_acc       = '0;
                    n_neg       = 1'b0;
                end else if (r_ns == 2'd0 && clt_pkg::is_space(i_byte)) begin
                    n_ns = r_ns;
                end else if (r_ns == 2'd0 &&
                             (i_byte == clt_pkg::CH_PLUS || i_byte == clt_pkg::CH_MINUS)) begin
                    n_neg = r_neg | (i_byte == clt_pkg::CH_MINUS);
                    n_ns  = 2'd1;
                end else if (r_ns != 2'd3 && clt_pkg::is_digit(i_byte)) begin
                    n_acc = (acc_mul > 21'(clt_pkg::NUM_SAT)) ? clt_pkg::NUM_SAT
                                                               : acc_mul[16:0];
                    n_ns  = 2'd2;
                end else begin
                    n_ns = 2'd3;
                end
            end
            // chunk index, then data length
            if (!r_colon) begin
                if (i_byte == clt_pkg::CH_COLON) begin
                    n_colon = 1'b1;
                end else if (clt_pkg::is_digit(i_byte)) begin
                    n_idx_any = 1'b1;
                    if (idx_mul > 20'(clt_pkg::IDX_SAT)) begin
                        n_idx_bad = 1'b1;
                        n_idx     = clt_pkg::IDX_SAT;
                    end else begin
                        n_idx = idx_mul[15:0];
                    end
                end else begin
                    n_idx_bad = 1'b1;
                end
            end else begin
                if (r_data_pos < DSAT) begin
                    n_data_pos = r_data_pos + DW'(1);
                end
                if (i_byte != clt_pkg::CH_CR) begin
                    n_kept = n_data_pos;
                end
            end
            if (r_pos < clt_pkg::POS_SAT) begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_trim      <= '0;
            r_begin_ok  <= 1'b1;
            r_end_ok    <= 1'b1;
            r_size_done <= 1'b0;
            r_size_neg  <= 1'b0;
            r_neg       <= 1'b0;
            r_ns        <= '0;
            r_acc       <= '0;
            r_hsize     <= '0;
            r_colon     <= 1'b0;
            r_idx_any   <= 1'b0;
            r_idx_bad   <= 1'b0;
            r_idx       <= '0;
            r_data_pos  <= '0;
            r_kept      <= '0;
        end else begin
            r_pos       <= n_pos;
            r_trim      <= n_trim;
            r_begin_ok  <= n_begin_ok;
            r_end_ok    <= n_end_ok;
            r_size_done <= n_size_done;
            r_size_neg  <= n_size_neg;
            r_neg       <= n_neg;
            r_ns        <= n_ns;
            r_acc       <= n_acc;
            r_hsize     <= n_hsize;
            r_colon     <= n_colon;
            r_idx_any   <= n_idx_any;
            r_idx_bad   <= n_idx_bad;
            r_idx       <= n_idx;
            r_data_pos  <= n_data_pos;
            r_kept      <= n_kept;
        end
    end

    always_comb begin
        o_info.begin_ok    = r_begin_ok;
        o_info.end_ok      = r_end_ok;
        o_info.trim        = r_trim;
        o_info.size_done   = r_size_done;
        o_info.size_neg    = r_size_neg;
        o_info.num_neg     = r_neg;
        o_info.header_size = r_hsize;
        o_info.number      = r_acc;
        o_info.colon_seen  = r_colon;
        o_info.idx_any     = r_idx_any;
        o_info.idx_bad     = r_idx_bad;
        o_info.index       = r_idx;
    end

    assign o_data_pos    = r_data_pos;
    assign o_kept_length = r_kept;

endmodule

FILE: hw/rtl/chunked_line_transfer_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_line_transfer_reassembler
// Reassembles a chunked payload sent as text lines and reads it out in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command per transfer:
//   link byte, tick, read payload byte, start, link lost or clear. Every
//   accepted command yields exactly one result transfer on the output channel
//   (o_out_valid / i_out_ready) with phase, error code, payload ready flag,
//   the read byte and its last flag, and the number of stored chunks.
//   One command is in work at a time. Bytes, ticks, start, link lost, clear
//   and a read with no payload ready go from idle straight to the response
//   state. A read walks the chunk slots: a chunk table RAM lookup (one read
//   per slot), a check of the slot, then the payload RAM read; a slot with
//   nothing left is passed over, and a read past the last slot ends bare.
//   The chunk table and the payload live in two synchronous RAMs; chunk
//   presence is kept in flip-flops and cleared as a whole vector.
//   Reset (synchronous, active low) puts the block in phase off with no
//   error and no chunk, timeout register 30000 ticks. The user writes it
//   via i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
//   When the receiver stalls, the result holds in the output register; the
//   block still accepts the next command and parks its result until the
//   output register frees up.
// ----------------------------------------------------------------------------
module chunked_line_transfer_reassembler #(
    parameter int PAYLOAD_MAX = clt_pkg::PAYLOAD_MAX_DEF,
    parameter int CHUNK_SLOTS = clt_pkg::CHUNK_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_link_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_phase,
    output logic [2:0]  o_error_code,
    output logic        o_payload_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_last,
    output logic [6:0]  o_chunks_stored,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata
);

    localparam int AW  = $clog2(PAYLOAD_MAX);
    localparam int LW  = $clog2(PAYLOAD_MAX + 1);
    localparam int DW  = $clog2(PAYLOAD_MAX + 2);
    localparam int IW  = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
    localparam int SCW = $clog2(CHUNK_SLOTS + 1);
    localparam int CW  = AW + LW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RESP    = 3'd1;
    localparam logic [2:0] S_RD_LOOK = 3'd2;
    localparam logic [2:0] S_RD_CHK  = 3'd3;
    localparam logic [2:0] S_RD_BYTE = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [2:0]             r_phase, n_phase;
    logic [2:0]             r_error, n_error;
    logic                   r_active, n_active;
    logic                   r_pready, n_pready;
    logic [LW-1:0]          r_exp_size, n_exp_size;
    logic [SCW-1:0]         r_exp_count, n_exp_count;
    logic [LW-1:0]          r_committed, n_committed;
    logic [SCW-1:0]         r_stored, n_stored;
    logic [CHUNK_SLOTS-1:0] r_present, n_present;
    logic [23:0]            r_elapsed, n_elapsed;
    logic [23:0]            r_timeout;
    logic [SCW-1:0]         r_read_slot, n_read_slot;
    logic [LW-1:0]          r_read_offset, n_read_offset;
    logic [LW-1:0]          r_read_total, n_read_total;
    logic [7:0]             r_rbyte, n_rbyte;
    logic                   r_rlast, n_rlast;

    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_o_phase, r_o_error;
    logic        r_o_pready, r_o_last;
    logic [7:0]  r_o_byte;
    logic [6:0]  r_o_stored;
    logic        out_load;

    logic                 accept;
    logic                 line_feed, line_clr;
    clt_pkg::t_line_info  info;
    logic [DW-1:0]        data_pos, kept_len;

    logic          do_fail, do_clear;
    logic [2:0]    fail_code, clear_phase;
    logic          hdr_bad, idx_bad;
    logic [IW-1:0] idx_sel, slot_sel;
    logic [31:0]   wr_sum;

    logic          pay_we, pay_re;
    logic [AW-1:0] pay_waddr, pay_raddr;
    logic [7:0]    pay_rdata;
    logic          chk_we, chk_re;
    logic [CW-1:0] chk_wdata, chk_rdata;
    logic [AW-1:0] slot_start;
    logic [LW-1:0] slot_len;
    logic [23:0]   tick_next;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign idx_sel    = info.index[IW-1:0];
    assign slot_sel   = r_read_slot[IW-1:0];
    assign slot_start = chk_rdata[CW-1:LW];
    assign slot_len   = chk_rdata[LW-1:0];
    assign wr_sum     = 32'(r_committed) + 32'(data_pos);
    assign tick_next  = (r_elapsed != clt_pkg::TICK_SAT) ? r_elapsed + 24'd1 : r_elapsed;

    assign hdr_bad = !info.size_done || info.size_neg || info.num_neg ||
                     info.header_size == '0 || 32'(info.header_size) > 32'(PAYLOAD_MAX) ||
                     info.number == '0 || 32'(info.number) > 32'(CHUNK_SLOTS);
    assign idx_bad = !info.idx_any || info.idx_bad ||
                     32'(info.index) >= 32'(r_exp_count) ||
                     32'(info.index) >= 32'(CHUNK_SLOTS);

    clt_line_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_feed        (line_feed),
        .i_clear       (line_clr),
        .i_byte        (i_link_byte),
        .o_info        (info),
        .o_data_pos    (data_pos),
        .o_kept_length (kept_len)
    );

    // payload bytes, addressed by commit offset plus position in the line
    clt_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (i_link_byte),
        .i_re    (pay_re),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rdata)
    );

    // chunk table: {start, length} per chunk index
    clt_ram #(
        .WIDTH (CW),
        .DEPTH (CHUNK_SLOTS)
    ) u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (chk_we),
        .i_waddr (idx_sel),
        .i_wdata (chk_wdata),
        .i_re    (chk_re),
        .i_raddr (slot_sel),
        .o_rdata (chk_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_error       = r_error;
        n_active      = r_active;
        n_pready      = r_pready;
        n_exp_size    = r_exp_size;
        n_exp_count   = r_exp_count;
        n_committed   = r_committed;
        n_stored      = r_stored;
        n_present     = r_present;
        n_elapsed     = r_elapsed;
        n_read_slot   = r_read_slot;
        n_read_offset = r_read_offset;
        n_read_total  = r_read_total;
        n_rbyte       = r_rbyte;
        n_rlast       = r_rlast;
        line_feed     = 1'b0;
        line_clr      = 1'b0;
        do_fail       = 1'b0;
        do_clear      = 1'b0;
        fail_code     = clt_pkg::ERR_NONE;
        clear_phase   = clt_pkg::PH_OFF;
        pay_we        = 1'b0;
        pay_waddr     = AW'(wr_sum);
        pay_re        = 1'b0;
        pay_raddr     = AW'(32'(slot_start) + 32'(r_read_offset));
        chk_we        = 1'b0;
        chk_wdata     = {AW'(r_committed), LW'(kept_len)};
        chk_re        = 1'b0;
        out_load      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rbyte = 8'd0;
                    n_rlast = 1'b0;
                    n_state = S_RESP;
                    case (i_command)
                        clt_pkg::CMD_BYTE: begin
                            if (r_phase == clt_pkg::PH_WAIT || r_phase == clt_pkg::PH_RECV) begin
                                if (i_link_byte == clt_pkg::CH_LF) begin
                                    line_clr = 1'b1;
                                    if (info.trim == 4'd0) begin
                                        n_state = S_RESP;
                                    end else if (info.end_ok && info.trim == clt_pkg::END_LEN) begin
                                        if (r_active) begin
                                            if (32'(r_committed) == 32'(r_exp_size)) begin
                                                n_pready      = 1'b1;
                                                n_read_slot   = '0;
                                                n_read_offset = '0;
                                                n_read_total  = '0;
                                                n_active      = 1'b0;
                                                n_phase       = clt_pkg::PH_COMPLETE;
                                            end else begin
                                                do_fail   = 1'b1;
                                                fail_code = clt_pkg::ERR_INVALID;
                                            end
                                        end
                                    end else if (info.begin_ok && info.trim >= 4'd8) begin
                                        if (hdr_bad) begin
                                            n_error = clt_pkg::ERR_INVALID;
                                        end else begin
                                            // restart the transfer and the timer
                                            n_present   = '0;
                                            n_stored    = '0;
                                            n_exp_size  = LW'(info.header_size);
                                            n_exp_count = SCW'(info.number);
                                            n_committed = '0;
                                            n_active    = 1'b1;
                                            n_elapsed   = '0;
                                            n_phase     = clt_pkg::PH_RECV;
                                        end
                                    end else if (r_active && info.colon_seen) begin
                                        if (idx_bad) begin
                                            n_error = clt_pkg::ERR_INVALID;
                                        end else if (!r_present[idx_sel]) begin
                                            if (32'(r_committed) + 32'(kept_len) >
                                                32'(PAYLOAD_MAX)) begin
                                                do_fail   = 1'b1;
                                                fail_code = clt_pkg::ERR_LARGE;
                                            end else begin
                                                chk_we             = 1'b1;
                                                n_present[idx_sel] = 1'b1;
                                                n_committed        = LW'(32'(r_committed) +
                                                                         32'(kept_len));
                                                n_stored           = r_stored + SCW'(1);
                                            end
                                        end
                                    end
                                end else begin
                                    line_feed = 1'b1;
                                    if (info.colon_seen && r_active &&
                                        wr_sum < 32'(PAYLOAD_MAX)) begin
                                        pay_we = 1'b1;
                                    end
                                end
                            end
                        end
                        clt_pkg::CMD_TICK: begin
                            if (r_phase == clt_pkg::PH_RECV && r_active) begin
                                n_elapsed = tick_next;
                                if (tick_next > r_timeout) begin
                                    do_fail   = 1'b1;
                                    fail_code = clt_pkg::ERR_TIMEOUT;
                                end
                            end
                        end
                        clt_pkg::CMD_READ: begin
                            if (r_pready) begin
                                n_state = S_RD_LOOK;
                            end
                        end
                        clt_pkg::CMD_START: begin
                            if (r_phase != clt_pkg::PH_WAIT && r_phase != clt_pkg::PH_RECV) begin
                                do_clear    = 1'b1;
                                clear_phase = clt_pkg::PH_WAIT;
                            end
                        end
                        clt_pkg::CMD_LOST: begin
                            if (r_phase == clt_pkg::PH_WAIT || r_phase == clt_pkg::PH_RECV) begin
                                do_fail   = 1'b1;
                                fail_code = clt_pkg::ERR_LOST;
                            end
                        end
                        clt_pkg::CMD_CLEAR: begin
                            do_clear    = 1'b1;
                            clear_phase = clt_pkg::PH_OFF;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_RD_LOOK: begin
                if (32'(r_read_slot) >= 32'(CHUNK_SLOTS)) begin
                    n_pready = 1'b0;
                    n_state  = S_RESP;
                end else begin
                    chk_re  = 1'b1;
                    n_state = S_RD_CHK;
                end
            end
            S_RD_CHK: begin
                if (r_present[slot_sel] && r_read_offset < slot_len) begin
                    pay_re        = 1'b1;
                    n_read_offset = r_read_offset + LW'(1);
                    n_read_total  = r_read_total + LW'(1);
                    if (32'(r_read_total) + 32'd1 >= 32'(r_exp_size)) begin
                        n_rlast  = 1'b1;
                        n_pready = 1'b0;
                    end
                    n_state = S_RD_BYTE;
                end else begin
                    // skip to the next slot
                    n_read_slot   = r_read_slot + SCW'(1);
                    n_read_offset = '0;
                    n_state       = S_RD_LOOK;
                end
            end
            S_RD_BYTE: begin
                n_rbyte = pay_rdata;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_fail) begin
            n_error   = fail_code;
            n_active  = 1'b0;
            n_present = '0;
            n_stored  = '0;
            line_clr  = 1'b1;
            n_phase   = clt_pkg::PH_ERROR;
        end
        if (do_clear) begin
            n_present     = '0;
            n_stored      = '0;
            line_clr      = 1'b1;
            n_error       = clt_pkg::ERR_NONE;
            n_exp_size    = '0;
            n_exp_count   = '0;
            n_committed   = '0;
            n_active      = 1'b0;
            n_pready      = 1'b0;
            n_elapsed     = '0;
            n_read_slot   = '0;
            n_read_offset = '0;
            n_read_total  = '0;
            n_phase       = clear_phase;
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= clt_pkg::PH_OFF;
            r_error       <= clt_pkg::ERR_NONE;
            r_active      <= 1'b0;
            r_pready      <= 1'b0;
            r_exp_size    <= '0;
            r_exp_count   <= '0;
            r_committed   <= '0;
            r_stored      <= '0;
            r_present     <= '0;
            r_elapsed     <= '0;
            r_timeout     <= clt_pkg::TIMEOUT_RESET;
            r_read_slot   <= '0;
            r_read_offset <= '0;
            r_read_total  <= '0;
            r_rbyte       <= 8'd0;
            r_rlast       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_error       <= n_error;
            r_active      <= n_active;
            r_pready      <= n_pready;
            r_exp_size    <= n_exp_size;
            r_exp_count   <= n_exp_count;
            r_committed   <= n_committed;
            r_stored      <= n_stored;
            r_present     <= n_present;
            r_elapsed     <= n_elapsed;
            r_read_slot   <= n_read_slot;
            r_read_offset <= n_read_offset;
            r_read_total  <= n_read_total;
            r_rbyte       <= n_rbyte;
            r_rlast       <= n_rlast;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_phase  <= r_phase;
            r_o_error  <= r_error;
            r_o_pready <= r_pready;
            r_o_byte   <= r_rbyte;
            r_o_last   <= r_rlast;
            r_o_stored <= (32'(r_stored) > 32'd127) ? 7'd127 : 7'(r_stored);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_phase         = r_o_phase;
    assign o_error_code    = r_o_error;
    assign o_payload_ready = r_o_pready;
    assign o_payload_byte  = r_o_byte;
    assign o_payload_last  = r_o_last;
    assign o_chunks_stored = r_o_stored;

endmodule

FILE: hw/rtl/clt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks of the reassembler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_phase,
    input logic [2:0]  o_error_code,
    input logic        o_payload_ready,
    input logic        o_payload_last,
    input logic [6:0]  o_chunks_stored
);

    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")
    `ASSERT_ON_VALID(a_last_ends, i_clk, i_rst_n, o_out_valid && o_payload_last,
        !o_payload_ready, "payload still ready after last byte")
    `ASSERT_ON_VALID(a_err_code, i_clk, i_rst_n, o_out_valid && o_phase == clt_pkg::PH_ERROR,
        o_error_code != clt_pkg::ERR_NONE, "error phase without error code")
    `ASSERT_ON_VALID(a_ready_done, i_clk, i_rst_n, o_out_valid && o_payload_ready,
        o_phase == clt_pkg::PH_COMPLETE, "payload ready outside complete phase")
    `ASSERT_ON_VALID(a_off_empty, i_clk, i_rst_n, o_out_valid && o_phase == clt_pkg::PH_OFF,
        o_chunks_stored == 7'd0, "chunks held while off")

endmodule

bind chunked_line_transfer_reassembler clt_checker u_clt_checker (.*);
